[rtl/remb_pkg.sv]
// Shared types, constants and helpers for the ROI emphasis map builder.
package remb_pkg;

    localparam int MB_SIZE      = 16;
    localparam int MB_SHIFT     = $clog2(MB_SIZE);
    localparam int MAX_MB_COLS  = 256;
    localparam int MAX_MB_ROWS  = 256;
    localparam int MAP_DEPTH    = MAX_MB_COLS * MAX_MB_ROWS;
    localparam int ADDR_W       = $clog2(MAP_DEPTH);

    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int GRID_W       = 12;
    localparam int IDX_W        = 16;
    localparam int QOFF_W       = 16;
    localparam int LVL_W        = 3;
    localparam int MBC_W        = $clog2(MAX_MB_COLS + 1);
    localparam int PROD_W       = 2 * CFG_W;

    localparam int EPOCH_W      = 4;
    localparam int RAM_W        = EPOCH_W + LVL_W;

    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [CFG_W-1:0] MAX_FRAME_W = CFG_W'(MAX_MB_COLS * MB_SIZE);
    localparam logic [CFG_W-1:0] MAX_FRAME_H = CFG_W'(MAX_MB_ROWS * MB_SIZE);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROI_BLK = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_W = 13'd1920;
    localparam logic [CFG_W-1:0] RST_FRAME_H = 13'd1080;
    localparam logic [CFG_W-1:0] RST_ROI_BLK = 13'd64;

    // Offset thresholds in thousandths and the levels they select
    localparam logic signed [QOFF_W-1:0] QTHR_HIGH = -16'sd350;
    localparam logic signed [QOFF_W-1:0] QTHR_MID  = -16'sd200;
    localparam logic [LVL_W-1:0] LVL_HIGH = 3'd5;
    localparam logic [LVL_W-1:0] LVL_MID  = 3'd3;
    localparam logic [LVL_W-1:0] LVL_LOW  = 3'd1;
    localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;

    localparam logic REQ_APPLY = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BAD_CFG = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_RESP = 2'd0,
        OP_WALK = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // One classified request on its way from the front to the back end
    typedef struct packed {
        op_t                op;
        logic               clear;
        status_t            status;
        logic [LVL_W-1:0]   level;
        logic [MBC_W-1:0]   x0;
        logic [MBC_W-1:0]   x1;
        logic [MBC_W-1:0]   y0;
        logic [MBC_W-1:0]   y1;
        logic [MBC_W-1:0]   mb_cols;
        logic [IDX_W-1:0]   mb_index;
    } cmd_t;

    function automatic logic [LVL_W-1:0] level_for_offset(input logic signed [QOFF_W-1:0] q);
        logic [LVL_W-1:0] lv;
        if (q <= QTHR_HIGH) begin
            lv = LVL_HIGH;
        end else if (q <= QTHR_MID) begin
            lv = LVL_MID;
        end else if (q < 0) begin
            lv = LVL_LOW;
        end else begin
            lv = LVL_NONE;
        end
        return lv;
    endfunction

endpackage

[rtl/remb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module remb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/remb_front.sv]
// Front end: configuration registers, request capture, range checks and rectangle clipping.
module remb_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic                                s_new_frame,
    input  logic [remb_pkg::GRID_W-1:0]         s_col,
    input  logic [remb_pkg::GRID_W-1:0]         s_row,
    input  logic [remb_pkg::GRID_W-1:0]         s_span_w,
    input  logic [remb_pkg::GRID_W-1:0]         s_span_h,
    input  logic signed [remb_pkg::QOFF_W-1:0]  s_qoffset_milli,
    input  logic [remb_pkg::IDX_W-1:0]          s_mb_index,
    input  logic                                cfg_we,
    input  logic [remb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [remb_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                init_done,
    input  logic                                q_full,
    output logic                                q_push,
    output remb_pkg::cmd_t                      q_cmd
);
    import remb_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [CFG_W-1:0]   fw_reg, fh_reg, rbs_reg;

    logic               req_reg, nf_reg;
    logic [GRID_W-1:0]  col_reg, row_reg, sw_reg, sh_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [PROD_W-1:0]  xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [2*MBC_W-1:0] total_reg;

    logic [PROD_W-1:0]  xlo_mul, xhi_mul, ylo_mul, yhi_mul;
    logic [2*MBC_W-1:0] total_mul;
    logic [CFG_W-1:0]   col_end, row_end;
    logic [CFG_W:0]     cols_sum, rows_sum;
    logic [MBC_W-1:0]   mb_cols, mb_rows;
    logic               cfg_ok;

    logic [PROD_W:0]    x1_full, y1_full;
    logic [CFG_W-1:0]   xc, yc;
    logic [CFG_W:0]     mx1_sum, my1_sum;
    logic               outside;
    cmd_t               cmd;

    // Derived layout
    assign cols_sum = {1'b0, fw_reg} + (CFG_W+1)'(MB_SIZE - 1);
    assign rows_sum = {1'b0, fh_reg} + (CFG_W+1)'(MB_SIZE - 1);
    assign mb_cols  = cols_sum[MB_SHIFT +: MBC_W];
    assign mb_rows  = rows_sum[MB_SHIFT +: MBC_W];
    assign cfg_ok   = (fw_reg != '0) && (fh_reg != '0) && (rbs_reg != '0)
                   && (fw_reg <= MAX_FRAME_W) && (fh_reg <= MAX_FRAME_H);

    // Last covered grid cell, inclusive
    assign col_end   = CFG_W'(col_reg) + CFG_W'(sw_reg) - CFG_W'(1);
    assign row_end   = CFG_W'(row_reg) + CFG_W'(sh_reg) - CFG_W'(1);
    assign xlo_mul   = CFG_W'(col_reg) * rbs_reg;
    assign ylo_mul   = CFG_W'(row_reg) * rbs_reg;
    assign xhi_mul   = col_end * rbs_reg;
    assign yhi_mul   = row_end * rbs_reg;
    assign total_mul = mb_cols * mb_rows;

    // The rectangle leaves the grid when its last cell starts at or past the frame edge
    assign outside = (xhi_reg >= PROD_W'(fw_reg)) || (yhi_reg >= PROD_W'(fh_reg));

    assign x1_full = {1'b0, xhi_reg} + (PROD_W+1)'(rbs_reg);
    assign y1_full = {1'b0, yhi_reg} + (PROD_W+1)'(rbs_reg);
    assign xc      = (x1_full > (PROD_W+1)'(fw_reg)) ? fw_reg : x1_full[CFG_W-1:0];
    assign yc      = (y1_full > (PROD_W+1)'(fh_reg)) ? fh_reg : y1_full[CFG_W-1:0];
    assign mx1_sum = {1'b0, xc} + (CFG_W+1)'(MB_SIZE - 1);
    assign my1_sum = {1'b0, yc} + (CFG_W+1)'(MB_SIZE - 1);

    always_comb begin
        cmd          = '0;
        cmd.clear    = (req_reg == REQ_APPLY) && nf_reg;
        cmd.x0       = xlo_reg[MB_SHIFT +: MBC_W];
        cmd.y0       = ylo_reg[MB_SHIFT +: MBC_W];
        cmd.x1       = mx1_sum[MB_SHIFT +: MBC_W];
        cmd.y1       = my1_sum[MB_SHIFT +: MBC_W];
        cmd.mb_cols  = mb_cols;
        cmd.mb_index = idx_reg;
        cmd.op       = OP_RESP;
        cmd.status   = ST_OK;
        cmd.level    = LVL_NONE;
        if (!cfg_ok) begin
            cmd.status = ST_BAD_CFG;
        end else if (req_reg == REQ_READ) begin
            if ((2*MBC_W)'(idx_reg) >= total_reg) begin
                cmd.status = ST_RANGE;
            end else begin
                cmd.op = OP_READ;
            end
        end else if (outside) begin
            cmd.status = ST_OUTSIDE;
        end else if (lvl_reg != LVL_NONE) begin
            cmd.op    = OP_WALK;
            cmd.level = lvl_reg;
        end
    end

    assign s_ready = (state_reg == F_IDLE) && init_done;
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_cmd   = cmd;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = F_CALC;
                end
            end
            F_CALC: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            fw_reg    <= RST_FRAME_W;
            fh_reg    <= RST_FRAME_H;
            rbs_reg   <= RST_ROI_BLK;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_IDX_FRAME_W: fw_reg  <= cfg_wdata;
                    CFG_IDX_FRAME_H: fh_reg  <= cfg_wdata;
                    CFG_IDX_ROI_BLK: rbs_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            nf_reg  <= s_new_frame;
            col_reg <= s_col;
            row_reg <= s_row;
            sw_reg  <= (s_span_w == '0) ? GRID_W'(1) : s_span_w;
            sh_reg  <= (s_span_h == '0) ? GRID_W'(1) : s_span_h;
            lvl_reg <= level_for_offset(s_qoffset_milli);
            idx_reg <= s_mb_index;
        end
        if (state_reg == F_CALC) begin
            xlo_reg   <= xlo_mul;
            xhi_reg   <= xhi_mul;
            ylo_reg   <= ylo_mul;
            yhi_reg   <= yhi_mul;
            total_reg <= total_mul;
        end
    end

endmodule

[rtl/remb_queue.sv]
// Short command queue between the front end and the back end.
module remb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  remb_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output remb_pkg::cmd_t  pop_cmd,
    output logic            empty
);
    import remb_pkg::*;

    cmd_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/remb_back.sv]
// Back end: map clearing, rectangle walk with read-modify-write, level reads and the result register.
module remb_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  remb_pkg::cmd_t              q_cmd,
    output logic                        init_done,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [remb_pkg::LVL_W-1:0]  m_level
);
    import remb_pkg::*;

    typedef enum logic [6:0] {
        B_SWEEP  = 7'b0000001,
        B_IDLE   = 7'b0000010,
        B_DISP   = 7'b0000100,
        B_WALK   = 7'b0001000,
        B_WLAST  = 7'b0010000,
        B_RDWAIT = 7'b0100000,
        B_RESP   = 7'b1000000
    } bstate_t;

    bstate_t            state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               init_done_reg, init_done_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic [MBC_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic [ADDR_W-1:0]  rb_reg, rb_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [LVL_W-1:0]   m_level_reg, m_level_next;

    logic [ADDR_W-1:0]  walk_addr;
    logic [2*MBC_W-1:0] rb_mul;
    logic [MBC_W-1:0]   x_inc, y_inc;
    logic [RAM_W-1:0]   rd_data;
    logic [LVL_W-1:0]   rd_cur, merged;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic               out_free;

    remb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign walk_addr = rb_reg + ADDR_W'(x_reg);
    assign rb_mul    = cmd_reg.y0 * cmd_reg.mb_cols;
    assign x_inc     = x_reg + MBC_W'(1);
    assign y_inc     = y_reg + MBC_W'(1);

    // An entry written under an older epoch reads as cleared
    assign rd_cur = (rd_data[LVL_W +: EPOCH_W] == epoch_reg) ? rd_data[LVL_W-1:0] : LVL_NONE;
    assign merged = (rd_cur < cmd_reg.level) ? cmd_reg.level : rd_cur;

    assign ram_we    = (state_reg == B_SWEEP) || pend_valid_reg;
    assign ram_waddr = (state_reg == B_SWEEP) ? sweep_reg : pend_addr_reg;
    assign ram_wdata = (state_reg == B_SWEEP) ? '0 : {epoch_reg, merged};
    assign ram_re    = (state_reg == B_WALK)
                    || ((state_reg == B_DISP) && !cmd_reg.clear && (cmd_reg.op == OP_READ));
    assign ram_raddr = (state_reg == B_WALK) ? walk_addr : cmd_reg.mb_index;

    assign out_free  = !m_valid_reg || m_ready;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        epoch_next      = epoch_reg;
        init_done_next  = init_done_reg;
        sweep_next      = sweep_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        rb_next         = rb_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_level_next    = m_level_reg;

        unique case (state_reg)
            B_SWEEP: begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (&sweep_reg) begin
                    init_done_next = 1'b1;
                    state_next     = init_done_reg ? B_DISP : B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    cmd_next   = q_cmd;
                    state_next = B_DISP;
                end
            end
            B_DISP: begin
                if (cmd_reg.clear) begin
                    // Advance the epoch; on wrap, scrub the whole map
                    cmd_next.clear = 1'b0;
                    if (&epoch_reg) begin
                        epoch_next = '0;
                        sweep_next = '0;
                        state_next = B_SWEEP;
                    end else begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                end else begin
                    unique case (cmd_reg.op)
                        OP_WALK: begin
                            x_next     = cmd_reg.x0;
                            y_next     = cmd_reg.y0;
                            rb_next    = rb_mul[ADDR_W-1:0];
                            state_next = B_WALK;
                        end
                        OP_READ: begin
                            state_next = B_RDWAIT;
                        end
                        default: begin
                            state_next = B_RESP;
                        end
                    endcase
                end
            end
            B_WALK: begin
                pend_valid_next = 1'b1;
                pend_addr_next  = walk_addr;
                if (x_inc == cmd_reg.x1) begin
                    if (y_inc == cmd_reg.y1) begin
                        state_next = B_WLAST;
                    end else begin
                        x_next  = cmd_reg.x0;
                        y_next  = y_inc;
                        rb_next = rb_reg + ADDR_W'(cmd_reg.mb_cols);
                    end
                end else begin
                    x_next = x_inc;
                end
            end
            B_WLAST: begin
                pend_valid_next = 1'b0;
                state_next      = B_RESP;
            end
            B_RDWAIT: begin
                cmd_next.level = rd_cur;
                state_next     = B_RESP;
            end
            B_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = cmd_reg.status;
                    m_level_next  = cmd_reg.level;
                    state_next    = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_SWEEP;
            epoch_reg      <= '0;
            init_done_reg  <= 1'b0;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            init_done_reg  <= init_done_next;
            sweep_reg      <= sweep_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        rb_reg        <= rb_next;
        pend_addr_reg <= pend_addr_next;
        m_status_reg  <= m_status_next;
        m_level_reg   <= m_level_next;
    end

    assign init_done = init_done_reg;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_level   = m_level_reg;

    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == B_WALK || state_reg == B_WLAST))
        else $error("pending map write outside a walk");

    a_err_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_level_reg == LVL_NONE))
        else $error("error result carries a nonzero level");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == B_RESP))
        else $error("result raised outside the response state");

    a_no_result_before_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done_reg |-> !m_valid_reg)
        else $error("result produced during the reset clearing pass");

endmodule

[rtl/roi_emphasis_map_builder.sv]
// Top level of the ROI emphasis map builder: front end, command queue and back end.
//
//   channel  | handshake            | word
//   ---------+----------------------+-----------------------------------------------
//   s_       | s_valid / s_ready    | req_type, new_frame, col, row, span_w, span_h,
//            |                      | qoffset_milli, mb_index
//   m_       | m_valid / m_ready    | status, level
//   cfg_     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// The front end takes a new word only when idle, checks it and queues a command; a full
// queue holds it back. The back end walks the macroblocks covered by an apply word, the
// map memory doing one read-modify-write per cycle. A read passes through dispatch,
// read-wait and response. A new frame only advances the epoch, except every 16th one,
// which scrubs the whole map. After reset, the map is scrubbed with s_ready held low.
// Up to 4 queued commands let s_ accept words while m_ is stalled.
module roi_emphasis_map_builder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic                                s_new_frame,
    input  logic [remb_pkg::GRID_W-1:0]         s_col,
    input  logic [remb_pkg::GRID_W-1:0]         s_row,
    input  logic [remb_pkg::GRID_W-1:0]         s_span_w,
    input  logic [remb_pkg::GRID_W-1:0]         s_span_h,
    input  logic signed [remb_pkg::QOFF_W-1:0]  s_qoffset_milli,
    input  logic [remb_pkg::IDX_W-1:0]          s_mb_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [remb_pkg::LVL_W-1:0]          m_level,
    input  logic                                cfg_we,
    input  logic [remb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [remb_pkg::CFG_W-1:0]          cfg_wdata
);
    import remb_pkg::*;

    // Queue hookup
    logic   q_push, q_full, q_pop, q_empty;
    cmd_t   push_cmd, pop_cmd;
    logic   init_done;

    // Capture, classify and clip; hold the word until the queue has room
    remb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_new_frame     (s_new_frame),
        .s_col           (s_col),
        .s_row           (s_row),
        .s_span_w        (s_span_w),
        .s_span_h        (s_span_h),
        .s_qoffset_milli (s_qoffset_milli),
        .s_mb_index      (s_mb_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .init_done       (init_done),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    // Decouple the front end from the map walk
    remb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // Clear, walk or read the map, then drive the result register
    remb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_cmd     (pop_cmd),
        .init_done (init_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_level   (m_level)
    );

endmodule
